// File: design/deq_pkg.sv
package deq_pkg;

   localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
   localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
   localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
   localparam logic [2:0] KIND_POP_BACK   = 3'd3;
   localparam logic [2:0] KIND_SEARCH     = 3'd4;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   // command queue between decode and execute
   localparam int CQ_DEPTH = 2;
   localparam int CQ_AW    = 1;

   typedef struct packed {
      logic        [2:0]  kind;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic        [1:0]  status;
      logic signed [31:0] result_value;
      logic               found;
      logic        [4:0]  fill_count;
      logic signed [31:0] head_value;
      logic signed [31:0] tail_value;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_NOP        = 3'd0,
      OP_PUSH_FRONT = 3'd1,
      OP_PUSH_BACK  = 3'd2,
      OP_POP_FRONT  = 3'd3,
      OP_POP_BACK   = 3'd4,
      OP_SEARCH     = 3'd5
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [31:0] value;
   } cmd_type;

endpackage

// File: design/deq_front.sv
module deq_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  deq_pkg::req_type  req,
   output logic              req_stall,
   output logic              cmd_valid,
   output deq_pkg::cmd_type  cmd,
   input  logic              cmd_stall
);
   import deq_pkg::*;

   op_type op;

   always_comb begin
      unique case (req.kind)
         KIND_PUSH_FRONT: op = OP_PUSH_FRONT;
         KIND_PUSH_BACK:  op = OP_PUSH_BACK;
         KIND_POP_FRONT:  op = OP_POP_FRONT;
         KIND_POP_BACK:   op = OP_POP_BACK;
         KIND_SEARCH:     op = OP_SEARCH;
         default:         op = OP_NOP;
      endcase
   end

   assign cmd_valid = req_valid;
   assign cmd.op    = op;
   assign cmd.value = req.value;
   assign req_stall = cmd_stall;

   // unused kind codes must not reach the executor as anything but a no-op
   a_unused_kind_nop: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req.kind > KIND_SEARCH) |-> (op == OP_NOP))
      else $error("unused kind not decoded as no-op");

endmodule

// File: design/deq_fifo.sv
module deq_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  deq_pkg::cmd_type  in_cmd,
   output logic              in_stall,
   output logic              out_valid,
   output deq_pkg::cmd_type  out_cmd,
   input  logic              out_stall
);
   import deq_pkg::*;

   cmd_type           slot_ff [CQ_DEPTH];
   logic [CQ_AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [CQ_AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CQ_AW:0]    cnt_ff, cnt_in;
   logic              push, pop;

   assign in_stall  = (cnt_ff == (CQ_AW+1)'(CQ_DEPTH));
   assign out_valid = (cnt_ff != '0);
   assign out_cmd   = slot_ff[rd_ptr_ff];
   assign push      = in_valid && !in_stall;
   assign pop       = out_valid && !out_stall;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == CQ_AW'(CQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == CQ_AW'(CQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      cnt_in = cnt_ff + (CQ_AW+1)'(push) - (CQ_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_cmd;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (CQ_AW+1)'(CQ_DEPTH))
      else $error("command queue overfilled");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("command queue pointers out of step");

endmodule

// File: design/deq_back.sv
module deq_back #(
   parameter int DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  deq_pkg::cmd_type  cmd,
   output logic              cmd_stall,
   output logic              rsp_valid,
   output deq_pkg::rsp_type  rsp,
   input  logic              rsp_stall
);
   import deq_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (CW > 5) ? CW : 5;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_READ = 4'b0010,
      ST_SRCH = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   state_type     state_ff, state_in;
   logic [AW-1:0] front_ff, front_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [31:0]   head_ff, head_in;
   logic [31:0]   tail_ff, tail_in;
   logic [31:0]   key_ff, key_in;
   logic [31:0]   pop_val_ff, pop_val_in;
   logic          read_front_ff, read_front_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          rd_vld_ff, rd_vld_in;
   rsp_type       res_ff, res_in;

   logic [31:0]   mem [DEPTH];
   logic [31:0]   rd_data_ff;
   logic          rd_en, wr_en;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [31:0]   wr_data;

   logic          full, empty;

   // ring index of front + off, off <= DEPTH
   function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                          input logic [CW-1:0] off);
      logic [CW:0] s;
      s = (CW+1)'(base) + (CW+1)'(off);
      if (s >= (CW+1)'(DEPTH)) begin
         s = s - (CW+1)'(DEPTH);
      end
      return s[AW-1:0];
   endfunction

   function automatic rsp_type mk_res(input logic [1:0]    st,
                                      input logic [31:0]   pv,
                                      input logic          fnd,
                                      input logic [CW-1:0] c,
                                      input logic [31:0]   h,
                                      input logic [31:0]   t);
      rsp_type         r;
      logic [XW-1:0]   ce;
      ce             = XW'(c);
      r.status       = st;
      r.result_value = pv;
      r.found        = fnd;
      r.fill_count   = ce[4:0];
      r.head_value   = (c == '0) ? '0 : h;
      r.tail_value   = (c == '0) ? '0 : t;
      return r;
   endfunction

   assign full      = (cnt_ff == CW'(DEPTH));
   assign empty     = (cnt_ff == '0);
   assign cmd_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_EMIT);
   assign rsp       = res_ff;

   always_comb begin
      state_in      = state_ff;
      front_in      = front_ff;
      cnt_in        = cnt_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      key_in        = key_ff;
      pop_val_in    = pop_val_ff;
      read_front_in = read_front_ff;
      idx_in        = idx_ff;
      rd_vld_in     = 1'b0;
      res_in        = res_ff;
      rd_en         = 1'b0;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = cmd.value;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               state_in = ST_EMIT;
               res_in   = mk_res(STATUS_OK, '0, 1'b0, cnt_ff, head_ff, tail_ff);
               case (cmd.op)
                  OP_PUSH_FRONT: begin
                     if (full) begin
                        res_in = mk_res(STATUS_FULL, '0, 1'b0, cnt_ff, head_ff, tail_ff);
                     end else begin
                        front_in = (front_ff == '0) ? AW'(DEPTH - 1) : front_ff - 1'b1;
                        wr_en    = 1'b1;
                        wr_addr  = front_in;
                        cnt_in   = cnt_ff + 1'b1;
                        head_in  = cmd.value;
                        if (empty) begin
                           tail_in = cmd.value;
                        end
                        res_in = mk_res(STATUS_OK, '0, 1'b0, cnt_in, head_in, tail_in);
                     end
                  end
                  OP_PUSH_BACK: begin
                     if (full) begin
                        res_in = mk_res(STATUS_FULL, '0, 1'b0, cnt_ff, head_ff, tail_ff);
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = slot(front_ff, cnt_ff);
                        cnt_in  = cnt_ff + 1'b1;
                        tail_in = cmd.value;
                        if (empty) begin
                           head_in = cmd.value;
                        end
                        res_in = mk_res(STATUS_OK, '0, 1'b0, cnt_in, head_in, tail_in);
                     end
                  end
                  OP_POP_FRONT: begin
                     if (empty) begin
                        res_in = mk_res(STATUS_EMPTY, '0, 1'b0, cnt_ff, head_ff, tail_ff);
                     end else begin
                        pop_val_in = head_ff;
                        front_in   = slot(front_ff, CW'(1));
                        cnt_in     = cnt_ff - 1'b1;
                        res_in     = mk_res(STATUS_OK, head_ff, 1'b0, cnt_in, head_ff,
                                            tail_ff);
                        if (cnt_in != '0) begin
                           // refetch the new front word
                           rd_en         = 1'b1;
                           rd_addr       = front_in;
                           read_front_in = 1'b1;
                           state_in      = ST_READ;
                        end
                     end
                  end
                  OP_POP_BACK: begin
                     if (empty) begin
                        res_in = mk_res(STATUS_EMPTY, '0, 1'b0, cnt_ff, head_ff, tail_ff);
                     end else begin
                        pop_val_in = tail_ff;
                        cnt_in     = cnt_ff - 1'b1;
                        res_in     = mk_res(STATUS_OK, tail_ff, 1'b0, cnt_in, head_ff,
                                            tail_ff);
                        if (cnt_in != '0) begin
                           rd_en         = 1'b1;
                           rd_addr       = slot(front_ff, cnt_in - 1'b1);
                           read_front_in = 1'b0;
                           state_in      = ST_READ;
                        end
                     end
                  end
                  OP_SEARCH: begin
                     key_in   = cmd.value;
                     idx_in   = '0;
                     state_in = ST_SRCH;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_EMIT;
            if (read_front_ff) begin
               head_in = rd_data_ff;
               res_in  = mk_res(STATUS_OK, pop_val_ff, 1'b0, cnt_ff, rd_data_ff, tail_ff);
            end else begin
               tail_in = rd_data_ff;
               res_in  = mk_res(STATUS_OK, pop_val_ff, 1'b0, cnt_ff, head_ff, rd_data_ff);
            end
         end
         ST_SRCH: begin
            // one read issued per cycle; the compare uses the registered read data
            if (rd_vld_ff && rd_data_ff == key_ff) begin
               res_in   = mk_res(STATUS_OK, '0, 1'b1, cnt_ff, head_ff, tail_ff);
               state_in = ST_EMIT;
            end else if (idx_ff < cnt_ff) begin
               rd_en     = 1'b1;
               rd_addr   = slot(front_ff, idx_ff);
               idx_in    = idx_ff + 1'b1;
               rd_vld_in = 1'b1;
            end else if (!rd_vld_ff) begin
               res_in   = mk_res(STATUS_OK, '0, 1'b0, cnt_ff, head_ff, tail_ff);
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         front_ff  <= '0;
         cnt_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         front_ff  <= front_in;
         cnt_ff    <= cnt_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff       <= head_in;
      tail_ff       <= tail_in;
      key_ff        <= key_in;
      pop_val_ff    <= pop_val_in;
      read_front_ff <= read_front_in;
      idx_ff        <= idx_in;
      res_ff        <= res_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(DEPTH))
      else $error("fill count beyond depth");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && res_ff.status == STATUS_FULL) |-> full)
      else $error("full status on a queue with room");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && res_ff.status == STATUS_EMPTY) |-> empty)
      else $error("empty status on a queue with words");

   a_read_follows_issue: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> ($past(rd_en) && $past(state_ff) == ST_IDLE))
      else $error("refetch state without a read issued");

endmodule

// File: design/double_ended_queue.sv
// channel | dir | handshake            | beat
// req_    | in  | req_valid/req_stall  | kind, value (req_type)
// rsp_    | out | rsp_valid/rsp_stall  | status, result_value, found, fill_count,
//         |     |                      | head_value, tail_value (rsp_type)
//
// Push and no-op results are registered straight from the command; pops refetch the new
// end word from the ring memory when words remain. Search walks the ring memory through
// its single read port, one word per cycle, and stops early on a hit.
// A two-beat command queue lets requests be taken while the executor is busy.
// Reset (synchronous) empties the queue; ring contents are not cleared.
// rsp_stall holds the result beat; the executor takes no new command meanwhile.
module double_ended_queue #(
   parameter int DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  deq_pkg::req_type  req,
   output logic              req_stall,
   output logic              rsp_valid,
   output deq_pkg::rsp_type  rsp,
   input  logic              rsp_stall
);
   import deq_pkg::*;

   logic    dec_valid, dec_stall;
   cmd_type dec_cmd;
   logic    exe_valid, exe_stall;
   cmd_type exe_cmd;

   deq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req       (req),
      .req_stall (req_stall),
      .cmd_valid (dec_valid),
      .cmd       (dec_cmd),
      .cmd_stall (dec_stall)
   );

   deq_fifo u_cmdq (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_cmd    (dec_cmd),
      .in_stall  (dec_stall),
      .out_valid (exe_valid),
      .out_cmd   (exe_cmd),
      .out_stall (exe_stall)
   );

   deq_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (exe_valid),
      .cmd       (exe_cmd),
      .cmd_stall (exe_stall),
      .rsp_valid (rsp_valid),
      .rsp       (rsp),
      .rsp_stall (rsp_stall)
   );

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import deq_pkg::*;

   localparam int DEPTH        = 16;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLDOFF_CYCLES = 300;

   // kind codes that the block treats as no-ops
   localparam logic [2:0] KIND_UNUSED_FIRST = 3'd5;
   localparam logic [2:0] KIND_UNUSED_LAST  = 3'd7;

   localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;

   logic    clock;
   logic    reset;
   logic    req_valid;
   req_type req;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp;
   logic    rsp_stall;

   // predicted deque contents
   logic signed [31:0] ring [DEPTH];
   logic [3:0]         front_index = '0;
   logic [4:0]         held_words  = '0;

   rsp_type expected_rsp[$];
   int      errors           = 0;
   int      cycle_count      = 0;
   int      sender_idle_pct  = 0;
   int      rsp_stall_pct    = 0;
   int      holdoff_left     = 0;
   int      holdoff_requests = 0;
   int      holdoff_served   = 0;

   double_ended_queue #(.DEPTH(DEPTH)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req       (req),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp       (rsp),
      .rsp_stall (rsp_stall)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [3:0] ring_slot(int unsigned offset);
      return front_index + offset[3:0];
   endfunction

   // applies one request to the predicted deque and returns the result beat
   function automatic rsp_type deque_predict(req_type item);
      rsp_type want;
      want = '0;
      case (item.kind) inside
         KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
            if (held_words == DEPTH) begin
               want.status = STATUS_FULL;
            end else if (item.kind == KIND_PUSH_FRONT) begin
               front_index = front_index - 4'd1;
               ring[front_index] = item.value;
               held_words++;
            end else begin
               ring[ring_slot(held_words)] = item.value;
               held_words++;
            end
         end
         KIND_POP_FRONT: begin
            if (held_words == 0) begin
               want.status = STATUS_EMPTY;
            end else begin
               want.result_value = ring[front_index];
               front_index = front_index + 4'd1;
               held_words--;
            end
         end
         KIND_POP_BACK: begin
            if (held_words == 0) begin
               want.status = STATUS_EMPTY;
            end else begin
               want.result_value = ring[ring_slot(held_words - 1)];
               held_words--;
            end
         end
         KIND_SEARCH: begin
            for (int i = 0; i < held_words; i++) begin
               if (ring[ring_slot(i)] == item.value) want.found = 1'b1;
            end
         end
         default: ;
      endcase
      want.fill_count = held_words;
      want.head_value = (held_words != 0) ? ring[front_index] : '0;
      want.tail_value = (held_words != 0) ? ring[ring_slot(held_words - 1)] : '0;
      return want;
   endfunction

   function automatic req_type request(logic [2:0] kind, logic signed [31:0] value);
      req_type item;
      item.kind  = kind;
      item.value = value;
      return item;
   endfunction

   function automatic logic signed [31:0] pick_word();
      case ($urandom_range(9)) inside
         0: return WORD_MIN;
         1: return WORD_MAX;
         2: return '0;
         3: return -32'sd1;
         4, 5, 6: return $urandom;
         default: return $urandom_range(15);   // small words give repeats
      endcase
   endfunction

   // half the time a held word when any are held, so searches hit
   function automatic logic signed [31:0] pick_search_word();
      if (held_words != 0 && $urandom_range(1) == 1)
         return ring[ring_slot($urandom_range(held_words - 1))];
      return pick_word();
   endfunction

   function automatic req_type random_request(int push_pct);
      req_type item;
      int      pick;
      pick = $urandom_range(99);
      if (pick < 3)
         item.kind = 3'($urandom_range(KIND_UNUSED_LAST, KIND_UNUSED_FIRST));
      else if (pick < push_pct)
         item.kind = $urandom_range(1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
      else if (pick < 88)
         item.kind = $urandom_range(1) ? KIND_POP_FRONT : KIND_POP_BACK;
      else
         item.kind = KIND_SEARCH;
      item.value = (item.kind == KIND_SEARCH) ? pick_search_word() : pick_word();
      return item;
   endfunction

   // called at a rising edge; returns at the edge where the beat is taken,
   // with valid still high
   task automatic send_request(req_type item);
      if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_valid <= 1'b1;
      req       <= item;
      do @(posedge clock); while (req_stall);
      expected_rsp.push_back(deque_predict(item));
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_rsp.size() != 0);
   endtask

   task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            $display("%0t: unexpected result beat: expected none, actual %h", $time, rsp);
            errors++;
         end else begin
            want = expected_rsp.pop_front();
            compare_field("status", 32'(want.status), 32'(rsp.status));
            compare_field("result_value", want.result_value, rsp.result_value);
            compare_field("found", 32'(want.found), 32'(rsp.found));
            compare_field("fill_count", 32'(want.fill_count), 32'(rsp.fill_count));
            compare_field("head_value", want.head_value, rsp.head_value);
            compare_field("tail_value", want.tail_value, rsp.tail_value);
         end
      end
   end

   // receiver: long hold-off when requested, random stalls otherwise
   always @(posedge clock) begin
      if (holdoff_served != holdoff_requests) begin
         holdoff_served = holdoff_requests;
         holdoff_left   = HOLDOFF_CYCLES;
      end
      if (holdoff_left > 0) begin
         rsp_stall <= 1'b1;
         holdoff_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("testbench: FAIL");
      $finish;
   end

   task automatic test_empty_queue();
      send_request(request(KIND_POP_FRONT, pick_word()));
      send_request(request(KIND_POP_BACK, pick_word()));
      send_request(request(KIND_SEARCH, '0));
      send_request(request(KIND_UNUSED_FIRST, pick_word()));
   endtask

   task automatic test_extreme_words();
      send_request(request(KIND_PUSH_FRONT, WORD_MIN));
      send_request(request(KIND_PUSH_BACK, WORD_MAX));
      send_request(request(KIND_PUSH_FRONT, -32'sd1));
      send_request(request(KIND_PUSH_BACK, '0));
      send_request(request(KIND_SEARCH, WORD_MAX));
      send_request(request(KIND_SEARCH, 32'sd1));
      send_request(request(KIND_UNUSED_LAST, WORD_MIN));
      send_request(request(KIND_POP_BACK, pick_word()));
      send_request(request(KIND_POP_FRONT, pick_word()));
      send_request(request(KIND_POP_BACK, pick_word()));
      // last word out leaves the queue empty
      send_request(request(KIND_POP_FRONT, pick_word()));
   endtask

   task automatic test_full_queue();
      for (int i = 0; i < DEPTH; i++) begin
         send_request(request(i[0] ? KIND_PUSH_FRONT : KIND_PUSH_BACK, pick_word()));
      end
      send_request(request(KIND_PUSH_FRONT, pick_word()));
      send_request(request(KIND_PUSH_BACK, pick_word()));
      send_request(request(KIND_SEARCH, pick_search_word()));
   endtask

   // receiver holds off long enough for the block to stall its input,
   // then the sender pauses until everything has drained
   task automatic test_backpressure();
      wait_for_results();
      @(negedge clock);
      holdoff_requests++;
      @(posedge clock);
      for (int i = 0; i < 24; i++) send_request(random_request(50));
      wait_for_results();
   endtask

   task automatic run_random(int count, int sender_pct, int stall_pct);
      int push_pct;
      sender_idle_pct = sender_pct;
      rsp_stall_pct   = stall_pct;
      push_pct        = 50;
      for (int n = 0; n < count; n++) begin
         // bursts biased toward filling or draining reach both ends
         if (n % 30 == 0) begin
            case ($urandom_range(2))
               0: push_pct = 30;
               1: push_pct = 50;
               default: push_pct = 75;
            endcase
         end
         send_request(random_request(push_pct));
      end
   endtask

   task automatic test_random_traffic();
      run_random(140, 0, 0);
      run_random(140, 80, 0);
      run_random(140, 0, 80);
      run_random(140, 33, 33);
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req       = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_queue();
      test_extreme_words();
      test_full_queue();
      test_backpressure();
      test_random_traffic();

      wait_for_results();
      sender_idle_pct = 0;
      rsp_stall_pct   = 0;
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && expected_rsp.size() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
